@@ hw/rtl/sslpc_pkg.sv @@
`default_nettype none

package sslpc_pkg;

   // Default number of servo channels.
   localparam int NUM_SERVOS_DEF = 8;

   // Field widths of the transaction payloads.
   localparam int POS_W   = 8;
   localparam int SPEED_W = 8;
   localparam int ACC_W   = 16;
   localparam int OFS_W   = 16;
   localparam int SCALE_W = 8;
   localparam int PULSE_W = 17;
   localparam int CHAN_W  = 3;

   // Ramp step is the accumulator shifted right by this amount.
   localparam int STEP_SHIFT = 5;

   // Operation codes of an input transaction.
   localparam logic OP_MOVE  = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   // Configuration register indexes and reset values.
   localparam int                 CSR_IDX_W        = 1;
   localparam int                 CSR_DATA_W       = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_OFFSET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_SCALE  = 1'b1;
   localparam logic [OFS_W-1:0]   OFFSET_RESET     = 16'd1000;
   localparam logic [SCALE_W-1:0] SCALE_RESET      = 8'd8;

   // Per-servo state.
   typedef struct packed {
      logic [POS_W-1:0]   pos;
      logic [POS_W-1:0]   goal;
      logic [SPEED_W-1:0] speed;
      logic [ACC_W-1:0]   acc;
      logic               active;
   } servo_state_type;

   localparam servo_state_type SERVO_RESET = '{
      pos:    8'd128,
      goal:   8'd0,
      speed:  8'd0,
      acc:    16'd0,
      active: 1'b0
   };

   // Output of the shared update unit for one servo.
   typedef struct packed {
      servo_state_type      next;
      logic [PULSE_W-1:0]   width;
   } servo_update_type;

endpackage

`default_nettype wire

@@ hw/rtl/servo_slew_limited_pulse_controller.sv @@
`default_nettype none

// Move transaction: no result, and the input stays ready.
// Frame transaction: one servo per cycle through the shared update unit while the output
// register can take a result; the sequencer enters its run state, then the first result is registered.
// The input is not ready while a frame sweep runs.
// Synchronous active-high reset: positions 128, all ramps idle, registers to defaults.
module servo_slew_limited_pulse_controller #(
   parameter int NUM_SERVOS = sslpc_pkg::NUM_SERVOS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [2:0]                          req_servo_index,
   input  logic [sslpc_pkg::POS_W-1:0]         req_target_position,
   input  logic [sslpc_pkg::SPEED_W-1:0]       req_move_speed,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sslpc_pkg::CHAN_W-1:0]        rsp_channel,
   output logic [sslpc_pkg::PULSE_W-1:0]       rsp_pulse_width,
   output logic [sslpc_pkg::POS_W-1:0]         rsp_new_position,
   output logic                                rsp_moving,
   output logic                                rsp_last_channel,
   input  logic                                csr_we,
   input  logic [sslpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sslpc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sslpc_pkg::*;

   localparam int IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SERVOS - 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                  state_ff, state_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic [OFS_W-1:0]      offset_ff, offset_in;
   logic [SCALE_W-1:0]    scale_ff, scale_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]     rsp_channel_ff, rsp_channel_in;
   logic [PULSE_W-1:0]    rsp_width_ff, rsp_width_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic                  rsp_moving_ff, rsp_moving_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  step_en;
   logic                  in_range;
   logic                  move_en;
   logic                  frame_go;
   logic [IDX_W-1:0]      req_idx;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      wr_addr;
   logic                  wr_en;
   servo_state_type       rd_data;
   servo_state_type       wr_data;
   servo_state_type       move_data;
   servo_update_type      upd;

   // Handshake decode.
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_en   = (state_ff == ST_RUN) && out_free;
   assign in_range  = 32'(req_servo_index) < NUM_SERVOS;
   assign req_idx   = IDX_W'(req_servo_index);
   assign move_en   = req_valid && req_ready && (req_op == OP_MOVE) && in_range;
   assign frame_go  = req_valid && req_ready && (req_op == OP_FRAME);

   // The state file has one read port, shared by move updates and the frame sweep.
   assign rd_addr = (state_ff == ST_RUN) ? cnt_ff : req_idx;

   sslpc_state_file #(
      .NUM_SERVOS (NUM_SERVOS),
      .IDX_W      (IDX_W)
   ) u_state (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sslpc_ramp_unit u_ramp (
      .pulse_offset (offset_ff),
      .pulse_scale  (scale_ff),
      .cur          (rd_data),
      .upd          (upd)
   );

   // Move command: jump at once with zero speed, otherwise arm a ramp.
   always_comb begin
      move_data = rd_data;
      if (req_move_speed == '0) begin
         move_data.pos    = req_target_position;
         move_data.active = 1'b0;
      end else begin
         move_data.goal   = req_target_position;
         move_data.speed  = req_move_speed;
         move_data.active = 1'b1;
      end
   end

   // State write-back: sweep step or move command.
   assign wr_en   = step_en || move_en;
   assign wr_addr = step_en ? cnt_ff : req_idx;
   assign wr_data = step_en ? upd.next : move_data;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (frame_go) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            if (step_en) begin
               if (cnt_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration registers.
   always_comb begin
      offset_in = offset_ff;
      scale_in  = scale_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PULSE_OFFSET: offset_in = csr_wdata;
            CSR_PULSE_SCALE:  scale_in  = csr_wdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Output register, loaded once per servo of the sweep.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_channel_in = rsp_channel_ff;
      rsp_width_in   = rsp_width_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_moving_in  = rsp_moving_ff;
      rsp_last_in    = rsp_last_ff;
      if (step_en) begin
         rsp_valid_in   = 1'b1;
         rsp_channel_in = CHAN_W'(cnt_ff);
         rsp_width_in   = upd.width;
         rsp_pos_in     = upd.next.pos;
         rsp_moving_in  = upd.next.active;
         rsp_last_in    = (cnt_ff == LAST_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         offset_ff    <= OFFSET_RESET;
         scale_ff     <= SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         offset_ff    <= offset_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_channel_ff <= rsp_channel_in;
      rsp_width_ff   <= rsp_width_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_moving_ff  <= rsp_moving_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_pulse_width  = rsp_width_ff;
   assign rsp_new_position = rsp_pos_ff;
   assign rsp_moving       = rsp_moving_ff;
   assign rsp_last_channel = rsp_last_ff;

endmodule

`default_nettype wire

@@ hw/rtl/sslpc_state_file.sv @@
`default_nettype none

module sslpc_state_file #(
   parameter int NUM_SERVOS = 8,
   parameter int IDX_W      = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [IDX_W-1:0]          wr_addr,
   input  sslpc_pkg::servo_state_type wr_data,
   input  logic [IDX_W-1:0]          rd_addr,
   output sslpc_pkg::servo_state_type rd_data
);
   import sslpc_pkg::*;

   servo_state_type entries_ff [NUM_SERVOS];
   servo_state_type entries_in [NUM_SERVOS];

   // Single write port.
   always_comb begin
      entries_in = entries_ff;
      if (wr_en) begin
         entries_in[wr_addr] = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SERVOS; i++) begin
            entries_ff[i] <= SERVO_RESET;
         end
      end else begin
         entries_ff <= entries_in;
      end
   end

   // Single read port, selected by the sequencer.
   assign rd_data = entries_ff[rd_addr];

endmodule

`default_nettype wire

@@ hw/rtl/sslpc_ramp_unit.sv @@
`default_nettype none

module sslpc_ramp_unit (
   input  logic                          [sslpc_pkg::OFS_W-1:0]   pulse_offset,
   input  logic                          [sslpc_pkg::SCALE_W-1:0] pulse_scale,
   input  sslpc_pkg::servo_state_type    cur,
   output sslpc_pkg::servo_update_type   upd
);
   import sslpc_pkg::*;

   localparam int DELTA_HI = STEP_SHIFT + POS_W - 1;

   logic [ACC_W-1:0]             acc_sum;
   logic [POS_W-1:0]             delta;
   logic [POS_W-1:0]             gap;
   logic [POS_W-1:0]             stepped;
   logic                         up;
   logic [OFS_W-1:0]             product;
   servo_state_type              nxt;

   // Ramp step: accumulate speed, take the whole units, clamp at the goal.
   always_comb begin
      acc_sum = cur.acc + ACC_W'(cur.speed);
      delta   = acc_sum[DELTA_HI:STEP_SHIFT];
      up      = cur.goal > cur.pos;
      gap     = up ? (cur.goal - cur.pos) : (cur.pos - cur.goal);
      stepped = up ? (cur.pos + delta) : (cur.pos - delta);
      nxt     = cur;
      if (cur.active) begin
         if (cur.goal == cur.pos) begin
            // Ramp found at its goal: end it without a step.
            nxt.active = 1'b0;
            nxt.acc    = '0;
         end else begin
            nxt.pos = (delta > gap) ? cur.goal : stepped;
            nxt.acc = (delta != '0) ? '0 : acc_sum;
         end
      end
   end

   // Pulse width uses the position before this frame's step.
   assign product   = {8'd0, cur.pos} * {8'd0, pulse_scale};
   assign upd.next  = nxt;
   assign upd.width = PULSE_W'(pulse_offset) + PULSE_W'(product);

endmodule

`default_nettype wire

@@ hw/rtl/sslpc_checker.sv @@
`default_nettype none

module sslpc_checker #(
   parameter int NUM_SERVOS = sslpc_pkg::NUM_SERVOS_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_op,
   input logic [2:0]                          req_servo_index,
   input logic [sslpc_pkg::POS_W-1:0]         req_target_position,
   input logic [sslpc_pkg::SPEED_W-1:0]       req_move_speed,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [sslpc_pkg::CHAN_W-1:0]        rsp_channel,
   input logic [sslpc_pkg::PULSE_W-1:0]       rsp_pulse_width,
   input logic [sslpc_pkg::POS_W-1:0]         rsp_new_position,
   input logic                                rsp_moving,
   input logic                                rsp_last_channel,
   input logic                                csr_we,
   input logic [sslpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [sslpc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sslpc_pkg::*;

   // No result is shown right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A frame transaction starts a sweep that blocks the input.
   a_frame_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OP_FRAME) |=> !req_ready)
      else $error("input ready right after a frame transaction");

   // The final result of a frame carries the highest channel.
   a_last_chan: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_channel) |-> rsp_channel == CHAN_W'(NUM_SERVOS - 1))
      else $error("last result on wrong channel");

   // While earlier results of a frame are pending, the input stays blocked.
   a_sweep_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_channel) |-> !req_ready)
      else $error("input ready in the middle of a frame");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_channel)
         && $stable(rsp_pulse_width) && $stable(rsp_new_position))
      else $error("stalled result changed");

endmodule

bind servo_slew_limited_pulse_controller sslpc_checker #(
   .NUM_SERVOS (NUM_SERVOS)
) u_sslpc_checker (.*);

`default_nettype wire

@@ tb/sv/tb.sv @@
`default_nettype none

module tb;
   import sslpc_pkg::*;

   localparam int NUM_SERVOS  = NUM_SERVOS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SHOW_LIMIT  = 10;

   // One expected channel result of a frame sweep.
   typedef struct {
      logic [CHAN_W-1:0]  channel;
      logic [PULSE_W-1:0] pulse_width;
      logic [POS_W-1:0]   new_position;
      logic               moving;
      logic               last_channel;
   } channel_pulse_type;

   // Tracks servo state, predicts frame results and compares them in order.
   class servo_frame_scoreboard;
      servo_state_type   servo[NUM_SERVOS];
      logic [OFS_W-1:0]   offset;
      logic [SCALE_W-1:0] scale;
      channel_pulse_type  expected_pulses[$];
      int                 mismatches;
      int                 pulses_checked;
      int                 frames;
      int                 moves;

      function new();
         foreach (servo[s]) servo[s] = SERVO_RESET;
         offset         = OFFSET_RESET;
         scale          = SCALE_RESET;
         mismatches     = 0;
         pulses_checked = 0;
         frames         = 0;
         moves          = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_PULSE_OFFSET) offset = data[OFS_W-1:0];
         else if (idx == CSR_PULSE_SCALE) scale = data[SCALE_W-1:0];
      endfunction

      // Applies one accepted transaction and queues the results of a frame tick.
      function void apply_command(logic op, logic [2:0] idx, logic [POS_W-1:0] tgt,
                                  logic [SPEED_W-1:0] spd);
         channel_pulse_type  p;
         logic [POS_W-1:0]   delta;
         logic [PULSE_W-1:0] width;
         if (op == OP_MOVE) begin
            moves++;
            if (int'(idx) >= NUM_SERVOS) return;
            if (spd == '0) begin
               servo[idx].pos    = tgt;
               servo[idx].active = 1'b0;
            end else begin
               servo[idx].speed  = spd;
               servo[idx].goal   = tgt;
               servo[idx].active = 1'b1;
            end
            return;
         end
         frames++;
         for (int s = 0; s < NUM_SERVOS; s++) begin
            // Pulse width comes from the position before this frame's step.
            width = PULSE_W'(offset) + PULSE_W'(servo[s].pos) * PULSE_W'(scale);
            if (servo[s].active) begin
               if (servo[s].goal == servo[s].pos) begin
                  // A ramp that already sits on its goal ends without a step.
                  servo[s].active = 1'b0;
                  servo[s].acc    = '0;
               end else begin
                  servo[s].acc = servo[s].acc + ACC_W'(servo[s].speed);
                  delta = POS_W'(servo[s].acc >> STEP_SHIFT);
                  if (servo[s].goal < servo[s].pos) begin
                     if (delta > servo[s].pos - servo[s].goal) servo[s].pos = servo[s].goal;
                     else servo[s].pos = servo[s].pos - delta;
                  end else begin
                     if (delta > servo[s].goal - servo[s].pos) servo[s].pos = servo[s].goal;
                     else servo[s].pos = servo[s].pos + delta;
                  end
                  // A zero step keeps the accumulated sum for the next frame.
                  if (delta != '0) servo[s].acc = '0;
               end
            end
            p.channel      = CHAN_W'(s);
            p.pulse_width  = width;
            p.new_position = servo[s].pos;
            p.moving       = servo[s].active;
            p.last_channel = (s == NUM_SERVOS - 1);
            expected_pulses.push_back(p);
         end
      endfunction

      // Compares one accepted result transaction with the oldest expectation.
      function void check_pulse(channel_pulse_type got);
         channel_pulse_type want;
         pulses_checked++;
         if (expected_pulses.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
               $display("ERROR: unexpected result chan=%0d width=%0d pos=%0d moving=%0d last=%0d",
                        got.channel, got.pulse_width, got.new_position, got.moving,
                        got.last_channel);
            return;
         end
         want = expected_pulses.pop_front();
         if (got.channel !== want.channel || got.pulse_width !== want.pulse_width ||
             got.new_position !== want.new_position || got.moving !== want.moving ||
             got.last_channel !== want.last_channel) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT) begin
               $display("ERROR: result mismatch, expected chan=%0d width=%0d pos=%0d %s%0d last=%0d,",
                        want.channel, want.pulse_width, want.new_position, "moving=",
                        want.moving, want.last_channel);
               $display("       got chan=%0d width=%0d pos=%0d moving=%0d last=%0d",
                        got.channel, got.pulse_width, got.new_position, got.moving,
                        got.last_channel);
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_op;
   logic [2:0]            req_servo_index;
   logic [POS_W-1:0]      req_target_position;
   logic [SPEED_W-1:0]    req_move_speed;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [CHAN_W-1:0]     rsp_channel;
   logic [PULSE_W-1:0]    rsp_pulse_width;
   logic [POS_W-1:0]      rsp_new_position;
   logic                  rsp_moving;
   logic                  rsp_last_channel;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   servo_frame_scoreboard sb;
   int                    rsp_stall_pct;
   int                    hold_cycles_req;
   int                    cycle_count;

   servo_slew_limited_pulse_controller dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_servo_index     (req_servo_index),
      .req_target_position (req_target_position),
      .req_move_speed      (req_move_speed),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_channel         (rsp_channel),
      .rsp_pulse_width     (rsp_pulse_width),
      .rsp_new_position    (rsp_new_position),
      .rsp_moving          (rsp_moving),
      .rsp_last_channel    (rsp_last_channel),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // Clock with a 20 unit period.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: random stalls, plus a long hold-off counted here when requested.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles_req != 0) begin
            hold_left       = hold_cycles_req;
            hold_cycles_req = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= (int'($urandom_range(99)) >= rsp_stall_pct);
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      channel_pulse_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.channel      = rsp_channel;
         got.pulse_width  = rsp_pulse_width;
         got.new_position = rsp_new_position;
         got.moving       = rsp_moving;
         got.last_channel = rsp_last_channel;
         sb.check_pulse(got);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Offers one transaction and waits until the block takes it.
   task automatic offer_command(logic op, logic [2:0] idx, logic [POS_W-1:0] tgt,
                                logic [SPEED_W-1:0] spd);
      req_valid           <= 1'b1;
      req_op              <= op;
      req_servo_index     <= idx;
      req_target_position <= tgt;
      req_move_speed      <= spd;
      do @(posedge clock); while (!req_ready);
      sb.apply_command(op, idx, tgt, spd);
   endtask

   // Lets every expected result drain, then waits for the block to settle.
   task automatic drain;
      req_valid <= 1'b0;
      while (sb.expected_pulses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes both registers while the block is idle.
   task automatic write_regs(logic [OFS_W-1:0] ofs, logic [SCALE_W-1:0] scl);
      csr_we    <= 1'b1;
      csr_index <= CSR_PULSE_OFFSET;
      csr_wdata <= CSR_DATA_W'(ofs);
      @(posedge clock);
      sb.write_reg(CSR_PULSE_OFFSET, CSR_DATA_W'(ofs));
      csr_index <= CSR_PULSE_SCALE;
      csr_wdata <= CSR_DATA_W'(scl);
      @(posedge clock);
      sb.write_reg(CSR_PULSE_SCALE, CSR_DATA_W'(scl));
      csr_we <= 1'b0;
   endtask

   // Random traffic: mostly ramps and frame ticks, some jumps and noisy targets.
   task automatic random_phase(int count, int idle_pct);
      logic [2:0]         idx;
      logic [POS_W-1:0]   tgt;
      logic [SPEED_W-1:0] spd;
      int                 kind;
      int                 t;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         idx  = 3'($urandom_range(7));
         tgt  = POS_W'($urandom_range(255));
         spd  = SPEED_W'($urandom_range(255));
         if (kind < 45) begin
            offer_command(OP_FRAME, idx, tgt, spd);
         end else if (kind < 85) begin
            // Ramps: often slow enough to show zero steps, often near the current spot.
            if ($urandom_range(2) != 0) spd = SPEED_W'($urandom_range(40, 1));
            else if (spd == '0) spd = SPEED_W'(1);
            if ($urandom_range(1) == 0) begin
               t = int'(sb.servo[idx].pos) + int'($urandom_range(12)) - 6;
               if (t < 0) t = 0;
               if (t > 255) t = 255;
               tgt = POS_W'(t);
            end
            offer_command(OP_MOVE, idx, tgt, spd);
         end else begin
            offer_command(OP_MOVE, idx, tgt, '0);
         end
         if (int'($urandom_range(99)) < idle_pct) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (int'($urandom_range(99)) < idle_pct);
         end
      end
   endtask

   // Main sequence.
   initial begin
      sb                  = new();
      cycle_count         = 0;
      rsp_stall_pct       = 0;
      hold_cycles_req     = 0;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_op              = OP_MOVE;
      req_servo_index     = '0;
      req_target_position = '0;
      req_move_speed      = '0;
      rsp_ready           = 1'b0;
      csr_we              = 1'b0;
      csr_index           = CSR_PULSE_OFFSET;
      csr_wdata           = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset register values.
      offer_command(OP_FRAME, 3'd0, 8'd0, 8'd0);
      offer_command(OP_MOVE, 3'd0, 8'd0, 8'd0);       // jump to the low end
      offer_command(OP_MOVE, 3'd7, 8'd255, 8'd0);     // jump to the high end
      offer_command(OP_MOVE, 3'd1, 8'd255, 8'd255);   // fastest ramp upward
      offer_command(OP_MOVE, 3'd2, 8'd130, 8'd255);   // step clamped at the goal
      offer_command(OP_MOVE, 3'd3, 8'd128, 8'd10);    // goal equal to the position
      offer_command(OP_MOVE, 3'd4, 8'd0, 8'd1);       // slowest ramp, zero steps
      offer_command(OP_MOVE, 3'd5, 8'd100, 8'd32);    // one unit per frame
      offer_command(OP_FRAME, 3'd7, 8'd255, 8'd255);
      offer_command(OP_FRAME, 3'd5, 8'd170, 8'd85);
      offer_command(OP_MOVE, 3'd1, 8'd200, 8'd0);     // jump ends a running ramp
      offer_command(OP_FRAME, 3'd2, 8'd85, 8'd170);
      offer_command(OP_MOVE, 3'd6, 8'd0, 8'd200);
      offer_command(OP_FRAME, 3'd0, 8'd0, 8'd0);
      offer_command(OP_MOVE, 3'd2, 8'd0, 8'd128);     // new goal keeps the accumulator
      offer_command(OP_FRAME, 3'd0, 8'd0, 8'd0);
      offer_command(OP_FRAME, 3'd0, 8'd0, 8'd0);
      offer_command(OP_MOVE, 3'd4, 8'd255, 8'd0);
      offer_command(OP_FRAME, 3'd0, 8'd0, 8'd0);
      drain();

      // Largest pulse settings, no idling, with one long receiver hold-off.
      write_regs(16'hFFFF, 8'hFF);
      hold_cycles_req = 300;
      random_phase(25, 0);
      drain();

      // Zero pulse settings, sender mostly idle.
      write_regs(16'h0000, 8'h00);
      random_phase(25, 80);
      drain();

      // Random settings, receiver mostly stalling.
      write_regs(OFS_W'($urandom_range(65535)), SCALE_W'($urandom_range(255)));
      rsp_stall_pct = 80;
      random_phase(25, 0);
      drain();

      // Moderate settings, both sides idling.
      write_regs(16'd1500, 8'd1);
      rsp_stall_pct = 36;
      random_phase(25, 36);
      drain();
      repeat (20) @(posedge clock);

      $display("Run covered %0d moves and %0d frame ticks; %0d channel results checked",
               sb.moves, sb.frames, sb.pulses_checked);
      $display("across four pacing modes, register extremes and a long output hold-off.");
      if (sb.mismatches == 0 && sb.expected_pulses.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/sslpc_pkg.sv
hw/rtl/sslpc_state_file.sv
hw/rtl/sslpc_ramp_unit.sv
hw/rtl/servo_slew_limited_pulse_controller.sv
hw/rtl/sslpc_checker.sv
tb/sv/tb.sv
